// File: rtl/rss_pkg.sv
`default_nettype none

package rss_pkg;

    localparam int VALUE_BITS_DEF = 16;
    localparam int ACC_BITS_DEF   = 32;

    localparam int SAMPLE_W = 32;
    localparam int CNT_W    = 32;
    localparam int OUT_W    = 16;
    localparam int PROD_W   = 64;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_CLEAR  = 2'd1;
    localparam logic [1:0] REQ_REPORT = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_AFTER_ERR = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [1:0] ST_SQ_OVF    = 2'd3;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [SAMPLE_W-1:0] sample_value;
    } in_t;

    typedef struct packed {
        logic [1:0]       sample_status;
        logic             stats_valid;
        logic [CNT_W-1:0] sample_count;
        logic [CNT_W-1:0] error_count;
        logic [OUT_W-1:0] min_value;
        logic [OUT_W-1:0] max_value;
        logic [OUT_W-1:0] mean_value;
        logic [OUT_W-1:0] deviation;
    } out_t;

endpackage

`default_nettype wire

// File: rtl/rss_report.sv
`default_nettype none

module rss_report #(
    parameter int ACC_BITS = rss_pkg::ACC_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [ACC_BITS-1:0]        total,
    input  wire logic [ACC_BITS-1:0]        square_total,
    input  wire logic [rss_pkg::CNT_W-1:0]  count,
    output logic                            done,
    output logic [ACC_BITS-1:0]             mean,
    output logic [ACC_BITS-1:0]             deviation
);

    localparam int CW = $clog2(ACC_BITS + 1);
    localparam int UW = (ACC_BITS + 1 > rss_pkg::PROD_W) ? ACC_BITS + 1 : rss_pkg::PROD_W;
    localparam int SQ_STEPS = (ACC_BITS - 1) / 2 + 1;
    localparam logic [ACC_BITS-1:0] SQ_START = ACC_BITS'(1) << (2 * ((ACC_BITS - 1) / 2));

    typedef enum logic [6:0] {
        P_IDLE = 7'b0000001,
        P_DIV1 = 7'b0000010,
        P_DIV2 = 7'b0000100,
        P_MUL  = 7'b0001000,
        P_SUB  = 7'b0010000,
        P_SQRT = 7'b0100000,
        P_DONE = 7'b1000000
    } phase_t;

    phase_t                       phase_reg, phase_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic [rss_pkg::CNT_W-1:0]    rem_reg, rem_next;
    logic [ACC_BITS-1:0]          dvd_reg, dvd_next;
    logic [ACC_BITS-1:0]          mean_reg, mean_next;
    logic [rss_pkg::PROD_W-1:0]   acc_reg, acc_next;
    logic [rss_pkg::PROD_W-1:0]   mcand_reg, mcand_next;
    logic [ACC_BITS-1:0]          res_reg, res_next;
    logic [ACC_BITS-1:0]          bit_reg, bit_next;

    logic [rss_pkg::CNT_W:0]      trial;
    logic [UW-1:0]                op_a, op_b;
    logic                         op_sub;
    logic [UW:0]                  alu_sum;
    logic [UW-1:0]                diff;
    logic                         carry;
    logic                         last;

    assign trial = {rem_reg, dvd_reg[ACC_BITS-1]};
    assign last  = (cnt_reg == '0);

    // Shared adder/subtractor; carry set on subtract means a >= b.
    always_comb
    begin
        unique case (phase_reg)
            P_DIV1, P_DIV2:
            begin
                op_a   = UW'(trial);
                op_b   = UW'(count);
                op_sub = 1'b1;
            end
            P_MUL:
            begin
                op_a   = UW'(acc_reg);
                op_b   = UW'(mcand_reg);
                op_sub = 1'b0;
            end
            P_SUB:
            begin
                op_a   = UW'(dvd_reg);
                op_b   = UW'(acc_reg);
                op_sub = 1'b1;
            end
            P_SQRT:
            begin
                op_a   = UW'(dvd_reg);
                op_b   = UW'(res_reg | bit_reg);
                op_sub = 1'b1;
            end
            default:
            begin
                op_a   = '0;
                op_b   = '0;
                op_sub = 1'b0;
            end
        endcase
    end

    assign alu_sum = {1'b0, op_a} + {1'b0, (op_sub ? ~op_b : op_b)} + (UW+1)'(op_sub);
    assign diff    = alu_sum[UW-1:0];
    assign carry   = alu_sum[UW];

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        mean_next  = mean_reg;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;

        unique case (phase_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    dvd_next   = total;
                    rem_next   = '0;
                    cnt_next   = CW'(ACC_BITS - 1);
                    phase_next = P_DIV1;
                end
            end
            P_DIV1, P_DIV2:
            begin
                rem_next = carry ? diff[rss_pkg::CNT_W-1:0] : trial[rss_pkg::CNT_W-1:0];
                dvd_next = {dvd_reg[ACC_BITS-2:0], carry};
                cnt_next = cnt_reg - CW'(1);
                if (last)
                begin
                    cnt_next = CW'(ACC_BITS - 1);
                    if (phase_reg == P_DIV1)
                    begin
                        mean_next  = {dvd_reg[ACC_BITS-2:0], carry};
                        dvd_next   = square_total;
                        rem_next   = '0;
                        phase_next = P_DIV2;
                    end
                    else
                    begin
                        acc_next   = '0;
                        mcand_next = rss_pkg::PROD_W'(mean_reg);
                        phase_next = P_MUL;
                    end
                end
            end
            P_MUL:
            begin
                // Shift-add square of the mean, wrapping at the product width.
                if (mean_reg[0])
                begin
                    acc_next = diff[rss_pkg::PROD_W-1:0];
                end
                mcand_next = mcand_reg << 1;
                mean_next  = {mean_reg[0], mean_reg[ACC_BITS-1:1]};
                cnt_next   = cnt_reg - CW'(1);
                if (last)
                begin
                    phase_next = P_SUB;
                end
            end
            P_SUB:
            begin
                dvd_next   = carry ? diff[ACC_BITS-1:0] : '0;
                res_next   = '0;
                bit_next   = SQ_START;
                cnt_next   = CW'(SQ_STEPS - 1);
                phase_next = P_SQRT;
            end
            P_SQRT:
            begin
                // res and bit never overlap, so OR stands for the add.
                if (carry)
                begin
                    dvd_next = diff[ACC_BITS-1:0];
                    res_next = (res_reg >> 1) | bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg - CW'(1);
                if (last)
                begin
                    phase_next = P_DONE;
                end
            end
            P_DONE:
            begin
                phase_next = P_IDLE;
            end
            default:
            begin
                phase_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        mean_reg  <= mean_next;
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        res_reg   <= res_next;
        bit_reg   <= bit_next;
    end

    assign done      = (phase_reg == P_DONE);
    assign mean      = mean_reg;
    assign deviation = res_reg;

endmodule

`default_nettype wire

// File: rtl/running_sample_statistics.sv
// Running sample statistics.
// Input channel in_valid/in_ready/in_data carries one request per beat: add a
// sample, clear the statistics or report them. Output channel
// out_valid/out_ready/out_data returns exactly one result beat per request.
// Requests are handled one at a time; in_ready is high only while no request
// is in progress, and the next request is taken while a result still waits.
// An add passes through S_SQR, S_UPD and S_FIN before its result is
// registered; a clear or a report with no samples goes straight to S_FIN. A
// report with samples runs the report unit: two restoring divisions and a
// shift-add square plus a square root of (ACC_BITS-1)/2+1 steps, all on one
// shared adder.
// A stalled receiver holds the result register; a finished request then waits
// in place until the register frees, and in_ready stays low meanwhile.
// Reset (rst_n low, asynchronous) empties both channels and restores the
// statistics: counts, sum and sum of squares to zero, minimum to all ones,
// maximum to zero.
`default_nettype none

module running_sample_statistics #(
    parameter int VALUE_BITS = rss_pkg::VALUE_BITS_DEF,
    parameter int ACC_BITS   = rss_pkg::ACC_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire rss_pkg::in_t  in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output rss_pkg::out_t      out_data
);

    localparam int SQ_W = 2 * VALUE_BITS;
    localparam int SW   = ((SQ_W > ACC_BITS) ? SQ_W : ACC_BITS) + 1;
    localparam int TW   = ((VALUE_BITS > ACC_BITS) ? VALUE_BITS : ACC_BITS) + 1;
    localparam logic [rss_pkg::SAMPLE_W-1:0] VAL_MAX =
        rss_pkg::SAMPLE_W'((64'd1 << VALUE_BITS) - 64'd1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SQR  = 5'b00010,
        S_UPD  = 5'b00100,
        S_RPT  = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    logic [rss_pkg::SAMPLE_W-1:0]    sample_reg, sample_next;
    logic [SQ_W-1:0]                 sq_reg, sq_next;
    logic [1:0]                      status_reg, status_next;
    logic                            rpt_reg, rpt_next;
    logic [rss_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [rss_pkg::CNT_W-1:0]       errors_reg, errors_next;
    logic [VALUE_BITS-1:0]           smallest_reg, smallest_next;
    logic [VALUE_BITS-1:0]           largest_reg, largest_next;
    logic [ACC_BITS-1:0]             total_reg, total_next;
    logic [ACC_BITS-1:0]             sqt_reg, sqt_next;
    logic                            out_valid_reg, out_valid_next;
    rss_pkg::out_t                   out_reg, out_next;

    logic                            accept;
    logic                            rpt_start;
    logic                            rpt_done;
    logic [ACC_BITS-1:0]             rpt_mean;
    logic [ACC_BITS-1:0]             rpt_dev;
    logic [VALUE_BITS-1:0]           val;
    logic [SW-1:0]                   sq_sum;
    logic [TW-1:0]                   t_sum;
    logic                            sq_ovf;
    logic                            t_sat;
    logic                            out_free;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign rpt_start = accept && (in_data.req_type == rss_pkg::REQ_REPORT)
                       && (count_reg != '0);
    assign out_free  = !out_valid_reg || out_ready;

    assign val    = sample_reg[VALUE_BITS-1:0];
    assign sq_sum = SW'(sq_reg) + SW'(sqt_reg);
    assign t_sum  = TW'(val) + TW'(total_reg);
    assign sq_ovf = |sq_sum[SW-1:ACC_BITS];
    assign t_sat  = |t_sum[TW-1:ACC_BITS];

    rss_report #(
        .ACC_BITS (ACC_BITS)
    ) u_report (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (rpt_start),
        .total        (total_reg),
        .square_total (sqt_reg),
        .count        (count_reg),
        .done         (rpt_done),
        .mean         (rpt_mean),
        .deviation    (rpt_dev)
    );

    always_comb
    begin
        state_next     = state_reg;
        sample_next    = sample_reg;
        sq_next        = sq_reg;
        status_next    = status_reg;
        rpt_next       = rpt_reg;
        count_next     = count_reg;
        errors_next    = errors_reg;
        smallest_next  = smallest_reg;
        largest_next   = largest_reg;
        total_next     = total_reg;
        sqt_next       = sqt_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sample_next = in_data.sample_value;
                    status_next = rss_pkg::ST_OK;
                    rpt_next    = rpt_start;
                    unique case (in_data.req_type)
                        rss_pkg::REQ_ADD:
                        begin
                            state_next = S_SQR;
                        end
                        rss_pkg::REQ_CLEAR:
                        begin
                            count_next    = '0;
                            errors_next   = '0;
                            smallest_next = '1;
                            largest_next  = '0;
                            total_next    = '0;
                            sqt_next      = '0;
                            state_next    = S_FIN;
                        end
                        rss_pkg::REQ_REPORT:
                        begin
                            state_next = (count_reg != '0) ? S_RPT : S_FIN;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_SQR:
            begin
                sq_next    = val * val;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                priority if (errors_reg != '0)
                begin
                    status_next = rss_pkg::ST_AFTER_ERR;
                end
                else if (sample_reg > VAL_MAX)
                begin
                    status_next = rss_pkg::ST_TOO_LARGE;
                end
                else if (sq_ovf)
                begin
                    status_next = rss_pkg::ST_SQ_OVF;
                end
                else
                begin
                    status_next = rss_pkg::ST_OK;
                end

                if ((errors_reg != '0) || (sample_reg > VAL_MAX) || sq_ovf)
                begin
                    if (errors_reg != '1)
                    begin
                        errors_next = errors_reg + rss_pkg::CNT_W'(1);
                    end
                end
                else
                begin
                    sqt_next = sq_sum[ACC_BITS-1:0];
                    if (val > largest_reg)
                    begin
                        largest_next = val;
                    end
                    if (val < smallest_reg)
                    begin
                        smallest_next = val;
                    end
                    total_next = t_sat ? '1 : t_sum[ACC_BITS-1:0];
                    if (count_reg != '1)
                    begin
                        count_next = count_reg + rss_pkg::CNT_W'(1);
                    end
                end
                state_next = S_FIN;
            end
            S_RPT:
            begin
                if (rpt_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // Hold here until the result register frees.
                if (out_free)
                begin
                    out_next.sample_status = status_reg;
                    out_next.stats_valid   = rpt_reg;
                    out_next.sample_count  = count_reg;
                    out_next.error_count   = errors_reg;
                    if (rpt_reg)
                    begin
                        out_next.min_value  = rss_pkg::OUT_W'(smallest_reg);
                        out_next.max_value  = rss_pkg::OUT_W'(largest_reg);
                        out_next.mean_value = rss_pkg::OUT_W'(rpt_mean);
                        out_next.deviation  = rss_pkg::OUT_W'(rpt_dev);
                    end
                    else
                    begin
                        out_next.min_value  = '0;
                        out_next.max_value  = '0;
                        out_next.mean_value = '0;
                        out_next.deviation  = '0;
                    end
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            rpt_reg       <= 1'b0;
            count_reg     <= '0;
            errors_reg    <= '0;
            smallest_reg  <= '1;
            largest_reg   <= '0;
            total_reg     <= '0;
            sqt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rpt_reg       <= rpt_next;
            count_reg     <= count_next;
            errors_reg    <= errors_next;
            smallest_reg  <= smallest_next;
            largest_reg   <= largest_next;
            total_reg     <= total_next;
            sqt_reg       <= sqt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        sq_reg     <= sq_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// File: dv/tb_running_sample_statistics.sv
`timescale 1ns / 1ps

module tb_running_sample_statistics;

    localparam logic [1:0]  REQ_UNUSED = 2'd3;
    localparam logic [63:0] VALUE_MAX  = 64'h0000_0000_0000_FFFF;
    localparam logic [63:0] ACC_MAX    = 64'h0000_0000_FFFF_FFFF;
    localparam logic [31:0] CNT_MAX    = 32'hFFFF_FFFF;
    localparam int          STIM_ITEMS = 525;
    localparam int          TAIL_CYCLES = 20;
    localparam int          CYCLE_LIMIT = 1000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    rss_pkg::in_t  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    rss_pkg::out_t out_data;

    running_sample_statistics dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #2 clk = ~clk;

    rss_pkg::in_t  pending_requests[$];
    rss_pkg::out_t expected_results[$];
    int   stim_items = 0;
    int   mismatch_count = 0;
    int   result_index = 0;
    int   cycle_count = 0;
    logic in_beat = 1'b0;

    // running statistics as the block should hold them
    logic [31:0] st_count;
    logic [31:0] st_errors;
    logic [15:0] st_min;
    logic [15:0] st_max;
    logic [31:0] st_total;
    logic [31:0] st_sq_total;

    task automatic clear_stats();
        st_count    = '0;
        st_errors   = '0;
        st_min      = '1;
        st_max      = '0;
        st_total    = '0;
        st_sq_total = '0;
    endtask

    function automatic logic [63:0] floor_sqrt(input logic [63:0] op);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bitv;
        rem  = op;
        root = '0;
        bitv = 64'h1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    task automatic predict_result(input rss_pkg::in_t req, output rss_pkg::out_t res);
        logic [63:0] val;
        logic [63:0] sq;
        logic [63:0] mean;
        logic [63:0] msq;
        logic [63:0] var_q;
        logic [63:0] dev_q;
        res = '0;
        val = {32'd0, req.sample_value};
        case (req.req_type)
            rss_pkg::REQ_ADD:
            begin
                sq = val * val;
                if (st_errors != 0)
                    res.sample_status = rss_pkg::ST_AFTER_ERR;
                else if (val > VALUE_MAX)
                    res.sample_status = rss_pkg::ST_TOO_LARGE;
                else if (sq > ACC_MAX - {32'd0, st_sq_total})
                    res.sample_status = rss_pkg::ST_SQ_OVF;
                if (res.sample_status != rss_pkg::ST_OK)
                begin
                    if (st_errors != CNT_MAX)
                        st_errors = st_errors + 1;
                end
                else
                begin
                    st_sq_total = st_sq_total + sq[31:0];
                    if (val[15:0] > st_max)
                        st_max = val[15:0];
                    if (val[15:0] < st_min)
                        st_min = val[15:0];
                    if (val > ACC_MAX - {32'd0, st_total})
                        st_total = ACC_MAX[31:0];
                    else
                        st_total = st_total + val[31:0];
                    if (st_count != CNT_MAX)
                        st_count = st_count + 1;
                end
            end
            rss_pkg::REQ_CLEAR:
                clear_stats();
            rss_pkg::REQ_REPORT:
            begin
                if (st_count != 0)
                begin
                    mean  = {32'd0, st_total} / {32'd0, st_count};
                    msq   = {32'd0, st_sq_total} / {32'd0, st_count};
                    var_q = (msq >= mean * mean) ? msq - mean * mean : 64'd0;
                    dev_q = floor_sqrt(var_q);
                    res.stats_valid = 1'b1;
                    res.min_value   = st_min;
                    res.max_value   = st_max;
                    res.mean_value  = mean[15:0];
                    res.deviation   = dev_q[15:0];
                end
            end
            default:
                ;
        endcase
        res.sample_count = st_count;
        res.error_count  = st_errors;
    endtask

    task automatic flag_mismatch(input string msg);
        $display("mismatch at result %0d: %s", result_index, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic push_req(input logic [1:0] kind, input logic [31:0] value);
        rss_pkg::in_t req;
        req.req_type     = kind;
        req.sample_value = value;
        pending_requests.push_back(req);
        if (kind != REQ_UNUSED)
            stim_items++;
    endtask

    function automatic logic [31:0] pick_sample(input int flavor);
        case (flavor)
            0: return $urandom_range(0, 255);
            1: return $urandom_range(0, 65535);
            2: return $urandom_range(40000, 65535);
            default:
                return ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 65535);
        endcase
    endfunction

    // driver: bursts of beats separated by random gaps
    int burst_left = 1;
    int gap_left = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !in_beat)
        begin
            // hold the beat until it is taken
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            in_valid <= 1'b0;
        end
        else if (pending_requests.size() > 0)
        begin
            in_valid <= 1'b1;
            in_data  <= pending_requests.pop_front();
            burst_left--;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 16);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // receiver: stall pattern switches between modes over time
    int rx_mode = 0;
    int mode_left = 0;
    int stall_left = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end
            else
            begin
                mode_left--;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (rx_mode == 1 && $urandom_range(0, 3) == 0)
            begin
                stall_left = $urandom_range(0, 3);
                out_ready <= 1'b0;
            end
            else if (rx_mode == 2 && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(5, 30);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        rss_pkg::out_t want;
        rss_pkg::out_t got;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = out_data;
                if (expected_results.size() == 0)
                begin
                    flag_mismatch("result beat with nothing pending");
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("sample_status", 32'(got.sample_status),
                                32'(want.sample_status));
                    check_field("stats_valid", 32'(got.stats_valid),
                                32'(want.stats_valid));
                    check_field("sample_count", got.sample_count, want.sample_count);
                    check_field("error_count", got.error_count, want.error_count);
                    check_field("min_value", 32'(got.min_value), 32'(want.min_value));
                    check_field("max_value", 32'(got.max_value), 32'(want.max_value));
                    check_field("mean_value", 32'(got.mean_value),
                                32'(want.mean_value));
                    check_field("deviation", 32'(got.deviation), 32'(want.deviation));
                end
                result_index++;
            end
            if (in_valid && in_ready)
            begin
                predict_result(in_data, want);
                expected_results.push_back(want);
            end
        end
        in_beat <= rst_n && in_valid && in_ready;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int n;
        int flavor;
        clear_stats();

        // directed: empty report, unused code, extremes, each rejection kind
        push_req(rss_pkg::REQ_REPORT, 32'd0);
        push_req(REQ_UNUSED, 32'hFFFF_FFFF);
        push_req(rss_pkg::REQ_ADD, 32'd0);
        push_req(rss_pkg::REQ_ADD, 32'd65535);
        push_req(rss_pkg::REQ_REPORT, 32'hFFFF_FFFF);
        push_req(rss_pkg::REQ_ADD, 32'd65535);
        push_req(rss_pkg::REQ_ADD, 32'd5);
        push_req(rss_pkg::REQ_ADD, 32'hFFFF_FFFF);
        push_req(rss_pkg::REQ_REPORT, 32'd0);
        push_req(REQ_UNUSED, 32'd0);
        push_req(rss_pkg::REQ_CLEAR, 32'hFFFF_FFFF);
        push_req(rss_pkg::REQ_ADD, 32'd65536);
        push_req(rss_pkg::REQ_CLEAR, 32'd0);
        push_req(rss_pkg::REQ_ADD, 32'hFFFF_FFFF);
        push_req(rss_pkg::REQ_CLEAR, 32'h5555_AAAA);
        push_req(rss_pkg::REQ_ADD, 32'd1);
        push_req(rss_pkg::REQ_ADD, 32'd2);
        push_req(rss_pkg::REQ_ADD, 32'd3);
        push_req(rss_pkg::REQ_ADD, 32'd1000);
        push_req(rss_pkg::REQ_REPORT, 32'd0);
        push_req(rss_pkg::REQ_CLEAR, 32'd0);
        push_req(rss_pkg::REQ_ADD, 32'd46340);
        push_req(rss_pkg::REQ_ADD, 32'd46340);
        push_req(rss_pkg::REQ_REPORT, 32'd0);
        push_req(rss_pkg::REQ_ADD, 32'd46340);

        // random: mostly clear, a run of samples and reports; some raw noise
        while (stim_items < STIM_ITEMS)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                push_req(rss_pkg::REQ_CLEAR, $urandom);
                n      = $urandom_range(1, 8);
                flavor = $urandom_range(0, 3);
                repeat (n)
                begin
                    push_req(rss_pkg::REQ_ADD, pick_sample(flavor));
                    if ($urandom_range(0, 3) == 0)
                        push_req(rss_pkg::REQ_REPORT, $urandom);
                end
                push_req(rss_pkg::REQ_REPORT, $urandom);
            end
            else
            begin
                push_req(2'($urandom_range(0, 3)), $urandom);
            end
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
